// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/lrar_pkg.sv =====
// types, codes and constant tables of the led ring renderer
package lrar_pkg;

  localparam int MAX_PIXELS_DEF = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;

  localparam longint COS_STEP_Q30 = 64'sd1073418433;
  localparam longint ONE_Q30      = 64'sd1073741824;

  typedef enum logic [2:0] {
    MODE_STATIC, MODE_BLINK, MODE_BREATHE, MODE_SPIN, MODE_CHASE, MODE_RAINBOW
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE, REG_SPEED, REG_BRIGHT, REG_COUNT
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD, OP_RENDER
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_D_TP, ST_D_PH, ST_D_TPN, ST_D_POS, ST_D_PN, ST_D_TDIV, ST_D_SPIN,
    ST_PX_HUE, ST_PX_RD, ST_PX_LVL, ST_PX_LG, ST_PX_CH, ST_PX_OUT
  } st_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] level;
    logic       blink;
  } pix_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [16:0] rem;
  } div_rsp_t;

  typedef logic [255:0][16:0] wtab_t;
  typedef logic [127:0][16:0] ltab_t;

  function automatic logic [16:0] quarter_cos(int m);
    longint prev;
    longint cur;
    longint nxt;
    prev = ONE_Q30;
    cur  = COS_STEP_Q30;
    if (m == 0) return 17'd65536;
    for (int k = 1; k < m && k < 64; k++) begin
      nxt  = (2 * COS_STEP_Q30 * cur) / ONE_Q30 - prev;
      prev = cur;
      cur  = nxt;
    end
    if (cur < 0) cur = 0;
    return 17'(cur >>> 14);
  endfunction

  function automatic logic [16:0] breathe_w(int k);
    int j;
    j = k;
    if (j > 128) j = 256 - j;
    if (j <= 64) return 17'((65536 - int'(quarter_cos(j))) / 2);
    return 17'((65536 + int'(quarter_cos(128 - j))) / 2);
  endfunction

  function automatic wtab_t build_breathe();
    wtab_t w;
    for (int k = 0; k < 256; k++) w[k] = breathe_w(k);
    return w;
  endfunction

  function automatic ltab_t build_level();
    ltab_t l;
    int lv;
    for (int k = 0; k < 128; k++) begin
      lv   = (k > 100) ? 100 : k;
      l[k] = 17'((lv * 65536) / 100);
    end
    return l;
  endfunction

  localparam wtab_t BREATHE_W = build_breathe();
  localparam ltab_t LEVEL_Q16 = build_level();

endpackage

// ===== src/lrar_if.sv =====
// valid/ready stream interfaces for load/render beats and pixel result beats
interface lrar_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [5:0]  pixel_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [6:0]  level_in;
  logic        blink_in;
  logic [31:0] time_ms;
  modport source (output valid, operation, pixel_index, red_in, green_in, blue_in,
                  level_in, blink_in, time_ms, input ready);
  modport sink (input valid, operation, pixel_index, red_in, green_in, blue_in,
                level_in, blink_in, time_ms, output ready);
endinterface

interface lrar_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;
  modport source (output valid, out_index, red_out, green_out, blue_out, frame_last,
                  input ready);
  modport sink (input valid, out_index, red_out, green_out, blue_out, frame_last,
                output ready);
endinterface

// ===== src/lrar_div.sv =====
// shared restoring divider, one quotient bit per cycle
module lrar_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrar_pkg::div_req_t req_i,
  output lrar_pkg::div_rsp_t rsp_o
);
  import lrar_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] dsr_q, dsr_d;
  logic [16:0] rem_q, rem_d;
  logic [17:0] sh;
  logic        ge;

  always_comb begin
    sh     = {rem_q, dvd_q[31]};
    ge     = sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? 17'(sh - {1'b0, dsr_q}) : sh[16:0];
      quo_d = {quo_q[30:0], ge};
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/lrar_pixmem.sv =====
// pixel table memory with per-entry valid bits cleared at reset
module lrar_pixmem #(
  parameter int DEPTH = lrar_pkg::MAX_PIXELS_DEF,
  parameter int IDX_W = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  lrar_pkg::pix_t     wdata_i,
  input  logic [IDX_W-1:0]   raddr_i,
  output lrar_pkg::pix_t     rdata_o
);
  import lrar_pkg::*;

  pix_t             mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  pix_t             rd_q;
  logic             rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      rvld_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

// ===== src/led_ring_animation_renderer.sv =====
// top level: sequencer and pixel datapath of the led ring renderer
// Usage: beats enter on in_bus, results leave on out_bus, both valid/ready.
// A load beat (operation 0) writes one pixel table entry and gives no
// result. A render beat (operation 1) gives one result beat per
// pixel in use, in ring order, the last one flagged by frame_last.
// A render first runs seven passes of the shared divider (time modulo the
// period, phase, chase position, spin offset); then the pixels are worked
// through one at a time, each with an extra hue division in rainbow mode.
// in_bus.ready is high only while no render runs.
// Results sit in an output register; while the receiver stalls the pixel
// walk waits for that register to empty, nothing is dropped.
// Reset clears the pixel table to black at level zero (per-entry valid
// bits, no clearing pass) and sets mode static, speed 5, brightness 8 and
// 64 pixels. Configuration writes through cfg_we_i take effect at the next
// render beat.
`include "assert_macros.svh"
module led_ring_animation_renderer #(
  parameter int MAX_PIXELS = lrar_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lrar_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lrar_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lrar_in_if.sink                        in_bus,
  lrar_out_if.source                     out_bus
);
  import lrar_pkg::*;

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [6:0] MAX_N = 7'(MAX_PIXELS);

  st_e         state_q, state_d;
  logic        issued_q, issued_d;
  logic [2:0]  cfg_mode_q;
  logic [3:0]  cfg_speed_q;
  logic [3:0]  cfg_bright_q;
  logic [6:0]  cfg_count_q;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        in_acc, render_acc, load_acc, slot_free, last_px, is_div;
  logic [6:0]  n_clamp;
  logic [3:0]  spd;
  logic [3:0]  brt;

  logic [31:0] t_q;
  mode_e       mode_q;
  logic [10:0] period_q;
  logic [7:0]  glob_q;
  logic [6:0]  n_q;
  logic [16:0] pn_q;
  logic [10:0] tm_q;
  logic [15:0] phase_q;
  logic [16:0] r2_q;
  logic [14:0] pos_q;
  logic [10:0] dv_q;
  logic [31:0] qd_q;
  logic [5:0]  off_q;
  logic [5:0]  pix_q;
  logic [7:0]  hq_q;
  logic [8:0]  f_q;
  logic [16:0] lvl_q;
  logic [2:0][7:0] col_q;
  logic [24:0] lg_q;
  logic [1:0]  ch_q;
  logic [2:0][7:0] res_q;

  logic        ovld_q;
  logic [5:0]  oidx_q;
  logic [2:0][7:0] ocol_q;
  logic        olast_q;

  pix_t        wpix;
  pix_t        rpix;
  logic [7:0]  sum8, src8;
  logic [5:0]  src;
  logic [14:0] me, dd, wrap, dm;
  logic [19:0] third;
  logic [8:0]  f_c;
  logic [16:0] lvl0, lvl_c, mop;
  logic [33:0] lprod;
  logic [7:0]  hue;
  logic [10:0] h6;
  logic [2:0]  sector;
  logic [8:0]  xr;
  logic [16:0] ramp17;
  logic [7:0]  ramp;
  logic [2:0][7:0] col_c;
  logic [32:0] cprod;
  logic [16:0] xs;
  logic [16:0] ys;

  lrar_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign wpix.red   = in_bus.red_in;
  assign wpix.green = in_bus.green_in;
  assign wpix.blue  = in_bus.blue_in;
  assign wpix.level = (in_bus.level_in > 7'd100) ? 7'd100 : in_bus.level_in;
  assign wpix.blink = in_bus.blink_in;

  lrar_pixmem #(
    .DEPTH (MAX_PIXELS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_acc && ({26'b0, in_bus.pixel_index} < MAX_PIXELS)),
    .waddr_i (in_bus.pixel_index[IDX_W-1:0]),
    .wdata_i (wpix),
    .raddr_i (src[IDX_W-1:0]),
    .rdata_o (rpix)
  );

  assign in_bus.ready = (state_q == ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign render_acc   = in_acc && (in_bus.operation == OP_RENDER);
  assign load_acc     = in_acc && (in_bus.operation == OP_LOAD);
  assign slot_free    = !ovld_q || out_bus.ready;
  assign last_px      = ({1'b0, pix_q} == n_q - 7'd1);
  assign n_clamp      = (cfg_count_q > MAX_N) ? MAX_N : cfg_count_q;
  assign spd          = (cfg_speed_q < 4'd1) ? 4'd1 :
                        ((cfg_speed_q > 4'd10) ? 4'd10 : cfg_speed_q);
  assign brt          = (cfg_bright_q < 4'd1) ? 4'd1 :
                        ((cfg_bright_q > 4'd8) ? 4'd8 : cfg_bright_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= 3'd0;
      cfg_speed_q  <= 4'd5;
      cfg_bright_q <= 4'd8;
      cfg_count_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   cfg_mode_q   <= cfg_data_i[2:0];
        REG_SPEED:  cfg_speed_q  <= cfg_data_i[3:0];
        REG_BRIGHT: cfg_bright_q <= cfg_data_i[3:0];
        REG_COUNT:  cfg_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (render_acc && n_clamp != 7'd0) state_d = ST_D_TP;
      ST_D_TP:   if (div_rsp.done) state_d = ST_D_PH;
      ST_D_PH:   if (div_rsp.done) state_d = ST_D_TPN;
      ST_D_TPN:  if (div_rsp.done) state_d = ST_D_POS;
      ST_D_POS:  if (div_rsp.done) state_d = ST_D_PN;
      ST_D_PN:   if (div_rsp.done) state_d = ST_D_TDIV;
      ST_D_TDIV: if (div_rsp.done) state_d = ST_D_SPIN;
      ST_D_SPIN: if (div_rsp.done) state_d = (mode_q == MODE_RAINBOW) ? ST_PX_HUE : ST_PX_RD;
      ST_PX_HUE: if (div_rsp.done) state_d = ST_PX_RD;
      ST_PX_RD:  state_d = ST_PX_LVL;
      ST_PX_LVL: state_d = ST_PX_LG;
      ST_PX_LG:  state_d = ST_PX_CH;
      ST_PX_CH:  if (ch_q == 2'd2) state_d = ST_PX_OUT;
      ST_PX_OUT: begin
        if (slot_free) begin
          if (last_px) state_d = ST_IDLE;
          else state_d = (mode_q == MODE_RAINBOW) ? ST_PX_HUE : ST_PX_RD;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    is_div           = 1'b1;
    div_req.dividend = t_q;
    div_req.divisor  = {6'b0, period_q};
    div_req.steps    = 6'd32;
    case (state_q)
      ST_D_TP:   ;
      ST_D_PH: begin
        div_req.dividend = {tm_q, 16'b0, 5'b0};
        div_req.steps    = 6'd27;
      end
      ST_D_TPN:  div_req.divisor = pn_q;
      ST_D_POS: begin
        div_req.dividend = {r2_q, 8'b0, 7'b0};
        div_req.steps    = 6'd25;
      end
      ST_D_PN: begin
        div_req.dividend = {period_q, 21'b0};
        div_req.divisor  = {10'b0, n_q};
        div_req.steps    = 6'd11;
      end
      ST_D_TDIV: div_req.divisor = {6'b0, dv_q};
      ST_D_SPIN: begin
        div_req.dividend = qd_q;
        div_req.divisor  = {10'b0, n_q};
      end
      ST_PX_HUE: begin
        div_req.dividend = {pix_q, 8'b0, 18'b0};
        div_req.divisor  = {10'b0, n_q};
        div_req.steps    = 6'd14;
      end
      default:   is_div = 1'b0;
    endcase
    div_req.start = is_div && !issued_q;
    issued_d      = div_rsp.done ? 1'b0 : (div_req.start ? 1'b1 : issued_q);
  end

  // spin source and chase falloff
  always_comb begin
    sum8  = {2'b0, pix_q} + {1'b0, n_q} - {2'b0, off_q};
    src8  = (sum8 >= {1'b0, n_q}) ? 8'(sum8 - {1'b0, n_q}) : sum8;
    src   = (mode_q == MODE_SPIN) ? src8[5:0] : pix_q;
    me    = {1'b0, pix_q, 8'b0};
    dd    = (me > pos_q) ? 15'(me - pos_q) : 15'(pos_q - me);
    wrap  = 15'({n_q, 8'b0} - dd);
    dm    = (wrap < dd) ? wrap : dd;
    third = 20'({dm[9:0], 1'b0}) * 20'd683;
    f_c   = (dm < 15'd384) ? 9'(9'd256 - third[19:11]) : 9'd0;
  end

  // level and colour of one pixel
  always_comb begin
    lvl0 = LEVEL_Q16[rpix.level];
    if (phase_q[15] && (mode_q == MODE_BLINK || rpix.blink)) lvl0 = '0;
    mop   = (mode_q == MODE_BREATHE) ? BREATHE_W[phase_q[15:8]] : {8'b0, f_q};
    lprod = lvl0 * mop;
    case (mode_q)
      MODE_BREATHE: lvl_c = lprod[32:16];
      MODE_CHASE:   lvl_c = lprod[24:8];
      default:      lvl_c = lvl0;
    endcase
    hue    = hq_q + phase_q[15:8];
    h6     = {1'b0, hue, 2'b0} + {2'b0, hue, 1'b0};
    sector = h6[10:8];
    xr     = sector[0] ? 9'(9'd256 - {1'b0, h6[7:0]}) : {1'b0, h6[7:0]};
    ramp17 = 17'({xr, 8'b0} - {8'b0, xr});
    ramp   = ramp17[15:8];
    col_c  = {rpix.blue, rpix.green, rpix.red};
    if (mode_q == MODE_RAINBOW) begin
      col_c = '0;
      case (sector)
        3'd0: begin col_c[0] = 8'd255; col_c[1] = ramp;   end
        3'd1: begin col_c[0] = ramp;   col_c[1] = 8'd255; end
        3'd2: begin col_c[1] = 8'd255; col_c[2] = ramp;   end
        3'd3: begin col_c[1] = ramp;   col_c[2] = 8'd255; end
        3'd4: begin col_c[0] = ramp;   col_c[2] = 8'd255; end
        3'd5: begin col_c[0] = 8'd255; col_c[2] = ramp;   end
        default: ;
      endcase
    end
    // divide by 255 for values below 65536
    cprod = {25'b0, col_q[ch_q]} * {8'b0, lg_q};
    xs    = cprod[32:16];
    ys    = 17'(xs + 17'd1 + {8'b0, xs[16:8]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (state_q == ST_PX_OUT && slot_free) ovld_q <= 1'b1;
      else if (out_bus.ready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_acc) begin
      t_q      <= in_bus.time_ms;
      mode_q   <= (cfg_mode_q > 3'd5) ? MODE_STATIC : mode_e'(cfg_mode_q);
      period_q <= 11'(12'd2200 - 12'(spd) * 12'd200);
      glob_q   <= 8'((9'd1 << brt) - 9'd1);
      n_q      <= n_clamp;
    end
    case (state_q)
      ST_D_TP: begin
        pn_q <= {6'b0, period_q} * {10'b0, n_q};
        if (div_rsp.done) tm_q <= div_rsp.rem[10:0];
      end
      ST_D_PH:   if (div_rsp.done) phase_q <= div_rsp.quot[15:0];
      ST_D_TPN:  if (div_rsp.done) r2_q <= div_rsp.rem;
      ST_D_POS:  if (div_rsp.done) pos_q <= div_rsp.quot[14:0];
      ST_D_PN: begin
        if (div_rsp.done)
          dv_q <= (div_rsp.quot[10:0] == 11'd0) ? 11'd1 : div_rsp.quot[10:0];
      end
      ST_D_TDIV: if (div_rsp.done) qd_q <= div_rsp.quot;
      ST_D_SPIN: begin
        if (div_rsp.done) begin
          off_q <= div_rsp.rem[5:0];
          pix_q <= '0;
        end
      end
      ST_PX_HUE: if (div_rsp.done) hq_q <= div_rsp.quot[7:0];
      ST_PX_RD:  f_q <= f_c;
      ST_PX_LVL: begin
        lvl_q <= lvl_c;
        col_q <= col_c;
      end
      ST_PX_LG: begin
        lg_q <= {8'b0, lvl_q} * {17'b0, glob_q};
        ch_q <= '0;
      end
      ST_PX_CH: begin
        res_q[ch_q] <= ys[15:8];
        ch_q        <= ch_q + 2'd1;
      end
      ST_PX_OUT: begin
        if (slot_free) begin
          oidx_q  <= pix_q;
          ocol_q  <= res_q;
          olast_q <= last_px;
          pix_q   <= pix_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_bus.valid      = ovld_q;
  assign out_bus.out_index  = oidx_q;
  assign out_bus.red_out    = ocol_q[0];
  assign out_bus.green_out  = ocol_q[1];
  assign out_bus.blue_out   = ocol_q[2];
  assign out_bus.frame_last = olast_q;

  `ASSERT_NEVER(a_div_start_busy, clk_i, rst_ni, div_req.start && div_rsp.busy, "divider restarted while busy")
  `ASSERT_CLK(a_idle_div_quiet, clk_i, rst_ni, in_bus.ready |-> !div_rsp.busy, "divider busy while idle")
  `ASSERT_CLK(a_pix_in_range, clk_i, rst_ni, (state_q == ST_PX_RD) |-> ({1'b0, pix_q} < n_q), "pixel walk past ring end")

endmodule
